// ===== src/mtp_pkg.sv =====
// shared constants, types and saturation helpers for the torque pid to pwm block
package mtp_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int SAMPLE_BITS = 16;
	localparam int MUL_STEPS   = 24;
	localparam int DIV_STEPS   = 48;
	localparam int CNT_W       = 6;

	localparam logic [18:0] TORQUE_K   = 19'd373759;
	localparam logic [10:0] RESET_DUTY = 11'd312;

	typedef enum logic [2:0] {
		CFG_SETPOINT = 3'd0,
		CFG_PROP     = 3'd1,
		CFG_INTEG    = 3'd2,
		CFG_DERIV    = 3'd3,
		CFG_LIMIT    = 3'd4,
		CFG_CENTER   = 3'd5,
		CFG_SPAN     = 3'd6
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EST_MUL1,
		ST_EST_MUL2,
		ST_EST_DIV,
		ST_ERR,
		ST_P,
		ST_I,
		ST_D,
		ST_ACC,
		ST_CLAMP,
		ST_LIN_MUL,
		ST_LIN_DIV,
		ST_OUT
	} seq_state_t;

	typedef enum logic {
		OP_MUL,
		OP_DIV
	} unit_op_t;

	typedef struct packed {
		logic        start;
		unit_op_t    op;
		logic [63:0] opa;
		logic [23:0] opb;
	} unit_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [63:0] result;
	} unit_rsp_t;

	function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
		logic signed [31:0] r;
		if (v > 65'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -65'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [39:0] sat40(input logic signed [64:0] v);
		logic signed [39:0] r;
		if (v > 65'sd549755813887) begin
			r = 40'sh7fffffffff;
		end else if (v < -65'sd549755813888) begin
			r = 40'sh8000000000;
		end else begin
			r = v[39:0];
		end
		return r;
	endfunction

endpackage

// ===== src/mtp_in_if.sv =====
// input item channel: current sample and encoder pulse rate
interface mtp_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] current_sample;
	logic [10:0] pulse_rate;

	modport source(output valid, output current_sample, output pulse_rate, input ready);
	modport sink(input valid, input current_sample, input pulse_rate, output ready);
endinterface

// ===== src/mtp_out_if.sv =====
// result item channel: duty, torque estimate and clamp flags
interface mtp_out_if;
	logic        valid;
	logic        ready;
	logic [10:0] duty;
	logic [31:0] torque_estimate;
	logic        at_upper_limit;
	logic        at_lower_limit;

	modport source(output valid, output duty, output torque_estimate,
		output at_upper_limit, output at_lower_limit, input ready);
	modport sink(input valid, input duty, input torque_estimate,
		input at_upper_limit, input at_lower_limit, output ready);
endinterface

// ===== src/mtp_cfg_if.sv =====
// configuration write channel: register index and write data
interface mtp_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [23:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ===== src/mtp_serial_unit.sv =====
// shared bit-serial multiply and restoring divide unit on one 64-bit adder
module mtp_serial_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mtp_pkg::unit_req_t   req,
	output mtp_pkg::unit_rsp_t   rsp
);
	import mtp_pkg::*;

	logic [63:0]      acc_q;
	logic [63:0]      sh_q;
	logic [23:0]      opb_q;
	unit_op_t         op_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [63:0] add_x;
	logic [63:0] add_y;
	logic        add_inv;
	logic [63:0] add_sum;

	// div: trial subtract of divisor from shifted remainder; mul: add of shifted multiplicand to the accumulator
	always_comb begin
		if (op_q == OP_DIV) begin
			add_x   = {39'b0, acc_q[23:0], sh_q[47]};
			add_y   = {40'b0, opb_q};
			add_inv = 1'b1;
		end else begin
			add_x   = acc_q;
			add_y   = sh_q;
			add_inv = 1'b0;
		end
		add_sum = add_x + (add_y ^ {64{add_inv}}) + {63'b0, add_inv};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= OP_MUL;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				cnt_q  <= (req.op == OP_DIV) ? CNT_W'(DIV_STEPS - 1) : CNT_W'(MUL_STEPS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			sh_q  <= req.opa;
			opb_q <= req.opb;
		end else if (busy_q) begin
			if (op_q == OP_DIV) begin
				acc_q <= add_sum[63] ? add_x : add_sum;
				sh_q  <= {sh_q[62:0], ~add_sum[63]};
			end else begin
				if (opb_q[0]) begin
					acc_q <= add_sum;
				end
				sh_q  <= {sh_q[62:0], 1'b0};
				opb_q <= {1'b0, opb_q[23:1]};
			end
		end
	end

	assign rsp.busy   = busy_q;
	assign rsp.done   = done_q;
	assign rsp.result = (op_q == OP_DIV) ? {16'b0, sh_q[47:0]} : acc_q;

endmodule

// ===== src/motor_torque_pid_to_pwm_core.sv =====
// top level: sequencer and datapath of the torque pid controller with pwm duty output
// One item per control tick. The block estimates torque from the current sample, the pulse
// rate and the duty applied on the last tick (zero when the rate is zero), runs an incremental
// pid step on the setpoint error and maps the saturated output accumulator to a pwm duty
// clamped between center and center plus span. All multiplies and divides run through one
// bit-serial unit: a multiply holds the sequencer through launch, 24 steps and done, and a
// divide through launch, 48 steps and done. A tick with a nonzero rate and a duty inside the
// linear range runs six multiplies, two divides and four steps that need no unit, and the next
// item can be taken in the cycle after the result load; a zero rate skips the two estimate
// multiplies and the estimate divide, and a clamped duty the linear multiply and divide. A
// stalled result side adds its stall to the tick. in_ch.ready is high only while no item is
// in work; the result sits in an output register, so the next item may enter while a result
// still waits. Configuration writes are always taken and must only come while the block is
// idle.
module motor_torque_pid_to_pwm_core (
	input  logic  clk,
	input  logic  arst_n,
	mtp_in_if.sink     in_ch,
	mtp_out_if.source  res_ch,
	mtp_cfg_if.sink    cfg_ch
);
	import mtp_pkg::*;

	// configuration registers
	logic signed [23:0] setpoint_q;
	logic [23:0]        prop_q;
	logic [23:0]        integ_q;
	logic [23:0]        deriv_q;
	logic [23:0]        limit_q;
	logic [9:0]         center_q;
	logic [9:0]         span_q;

	// controller state kept across ticks
	logic signed [31:0] prev_err_q;
	logic signed [39:0] esum_q;
	logic signed [31:0] accum_q;
	logic [10:0]        duty_now_q;

	// per-item working registers
	seq_state_t         state_q;
	seq_state_t         state_d;
	logic [15:0]        sample_q;
	logic [10:0]        rate_q;
	logic               neg_q;
	logic [10:0]        absd_q;
	logic [63:0]        t_q;
	logic signed [31:0] est_q;
	logic signed [31:0] err_q;
	logic signed [32:0] derr_q;
	logic signed [63:0] pid_q;
	logic [10:0]        duty_q;
	logic               up_q;
	logic               low_q;

	// output register
	logic               out_valid_q;
	logic [10:0]        out_duty_q;
	logic [31:0]        out_est_q;
	logic               out_up_q;
	logic               out_low_q;

	unit_req_t unit_req;
	unit_rsp_t unit_rsp;

	logic               in_fire;
	logic               out_load;
	logic               is_arith;
	logic [11:0]        dlt;
	logic [63:0]        qsh;
	logic signed [31:0] err_new;
	logic signed [39:0] esum_new;
	logic               clamp_up;
	logic               clamp_low;

	mtp_serial_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (unit_req),
		.rsp    (unit_rsp)
	);

	assign in_ch.ready  = (state_q == ST_IDLE);
	assign cfg_ch.ready = 1'b1;
	assign in_fire      = in_ch.valid && in_ch.ready;
	assign out_load     = (state_q == ST_OUT) && (!out_valid_q || res_ch.ready);

	// duty offset from center, applied duty of the last tick
	assign dlt = {1'b0, duty_now_q} - {2'b0, center_q};

	// quotient of |num| / rate, then truncating divide by 2^(32-frac)
	assign qsh = unit_rsp.result >> (32 - FRAC_BITS);

	// error and saturating error sum for this tick
	assign err_new  = sat32(65'(setpoint_q) - 65'(est_q));
	assign esum_new = sat40(65'(esum_q) + 65'(err_new));

	// clamp decisions on the freshly updated accumulator
	assign clamp_up  = $signed(33'(accum_q)) >= $signed({9'b0, limit_q});
	assign clamp_low = accum_q <= 32'sd0;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q <= 24'sd65536;
			prop_q     <= 24'd1638;
			integ_q    <= 24'd0;
			deriv_q    <= 24'd0;
			limit_q    <= 24'd229376;
			center_q   <= 10'd312;
			span_q     <= 10'd312;
		end else if (cfg_ch.valid && cfg_ch.ready) begin
			case (cfg_idx_t'(cfg_ch.index))
				CFG_SETPOINT: setpoint_q <= cfg_ch.data;
				CFG_PROP:     prop_q     <= cfg_ch.data;
				CFG_INTEG:    integ_q    <= cfg_ch.data;
				CFG_DERIV:    deriv_q    <= cfg_ch.data;
				CFG_LIMIT:    limit_q    <= cfg_ch.data;
				CFG_CENTER:   center_q   <= cfg_ch.data[9:0];
				CFG_SPAN:     span_q     <= cfg_ch.data[9:0];
				default: ;
			endcase
		end
	end

	// sequencer: next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_d = (in_ch.pulse_rate == '0) ? ST_ERR : ST_EST_MUL1;
				end
			end
			ST_EST_MUL1: if (unit_rsp.done) state_d = ST_EST_MUL2;
			ST_EST_MUL2: if (unit_rsp.done) state_d = ST_EST_DIV;
			ST_EST_DIV:  if (unit_rsp.done) state_d = ST_ERR;
			ST_ERR:      state_d = ST_P;
			ST_P:        if (unit_rsp.done) state_d = ST_I;
			ST_I:        if (unit_rsp.done) state_d = ST_D;
			ST_D:        if (unit_rsp.done) state_d = ST_ACC;
			ST_ACC:      state_d = ST_CLAMP;
			ST_CLAMP:    state_d = (clamp_up || clamp_low) ? ST_OUT : ST_LIN_MUL;
			ST_LIN_MUL:  if (unit_rsp.done) state_d = ST_LIN_DIV;
			ST_LIN_DIV:  if (unit_rsp.done) state_d = ST_OUT;
			ST_OUT:      if (out_load) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: operand selection for the shared unit
	always_comb begin
		is_arith     = 1'b0;
		unit_req.op  = OP_MUL;
		unit_req.opa = t_q;
		unit_req.opb = '0;
		case (state_q)
			ST_EST_MUL1: begin
				is_arith     = 1'b1;
				unit_req.opa = {48'b0, sample_q} << (16 - SAMPLE_BITS);
				unit_req.opb = {13'b0, absd_q};
			end
			ST_EST_MUL2: begin
				is_arith     = 1'b1;
				unit_req.opb = {5'b0, TORQUE_K};
			end
			ST_EST_DIV: begin
				is_arith     = 1'b1;
				unit_req.op  = OP_DIV;
				unit_req.opb = {13'b0, rate_q};
			end
			ST_P: begin
				is_arith     = 1'b1;
				unit_req.opa = 64'(err_q);
				unit_req.opb = prop_q;
			end
			ST_I: begin
				is_arith     = 1'b1;
				unit_req.opa = 64'(esum_q);
				unit_req.opb = integ_q;
			end
			ST_D: begin
				is_arith     = 1'b1;
				unit_req.opa = 64'(derr_q);
				unit_req.opb = deriv_q;
			end
			ST_LIN_MUL: begin
				is_arith     = 1'b1;
				unit_req.opa = {32'b0, accum_q};
				unit_req.opb = {14'b0, span_q};
			end
			ST_LIN_DIV: begin
				is_arith     = 1'b1;
				unit_req.op  = OP_DIV;
				unit_req.opb = limit_q;
			end
			default: ;
		endcase
		// launch once per state: unit idle and its result already taken
		unit_req.start = is_arith && !unit_rsp.busy && !unit_rsp.done;
	end

	// controller state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q <= '0;
			esum_q     <= '0;
			accum_q    <= '0;
			duty_now_q <= RESET_DUTY;
		end else begin
			if (state_q == ST_ERR) begin
				prev_err_q <= err_new;
				esum_q     <= esum_new;
			end
			if (state_q == ST_ACC) begin
				accum_q <= sat32(65'(accum_q) + 65'(pid_q));
			end
			if (out_load) begin
				duty_now_q <= duty_q;
			end
		end
	end

	// per-item datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					sample_q <= in_ch.current_sample;
					rate_q   <= in_ch.pulse_rate;
					neg_q    <= dlt[11];
					absd_q   <= dlt[11] ? 11'(-dlt) : dlt[10:0];
					est_q    <= '0;
				end
			end
			ST_EST_MUL1, ST_EST_MUL2, ST_LIN_MUL: begin
				if (unit_rsp.done) t_q <= unit_rsp.result;
			end
			ST_EST_DIV: begin
				if (unit_rsp.done) est_q <= neg_q ? -$signed(qsh[31:0]) : $signed(qsh[31:0]);
			end
			ST_ERR: begin
				err_q  <= err_new;
				derr_q <= 33'(err_new) - 33'(prev_err_q);
				pid_q  <= '0;
			end
			ST_P, ST_I, ST_D: begin
				// floor of gain * value / 2^frac
				if (unit_rsp.done) pid_q <= pid_q + ($signed(unit_rsp.result) >>> FRAC_BITS);
			end
			ST_CLAMP: begin
				up_q  <= clamp_up;
				low_q <= !clamp_up && clamp_low;
				if (clamp_up) begin
					duty_q <= {1'b0, center_q} + {1'b0, span_q};
				end else begin
					duty_q <= {1'b0, center_q};
				end
			end
			ST_LIN_DIV: begin
				if (unit_rsp.done) duty_q <= {1'b0, center_q} + {1'b0, unit_rsp.result[9:0]};
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (res_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_duty_q <= duty_q;
			out_est_q  <= est_q;
			out_up_q   <= up_q;
			out_low_q  <= low_q;
		end
	end

	assign res_ch.valid           = out_valid_q;
	assign res_ch.duty            = out_duty_q;
	assign res_ch.torque_estimate = out_est_q;
	assign res_ch.at_upper_limit  = out_up_q;
	assign res_ch.at_lower_limit  = out_low_q;

	// checks
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		res_ch.valid |-> !(res_ch.at_upper_limit && res_ch.at_lower_limit))
		else $error("both clamp flags set");

	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		unit_req.start |-> !unit_rsp.busy)
		else $error("shared unit started while busy");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ch.ready)
		else $error("ready stayed high after an item was taken");

	a_lower_is_center: assert property (@(posedge clk) disable iff (!arst_n)
		(res_ch.valid && res_ch.at_lower_limit) |-> (res_ch.duty == {1'b0, center_q}))
		else $error("lower clamp duty differs from center");

endmodule
